// ===== design/assert_macros.svh =====
// Assertion macros for the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/fdsd_pkg.sv =====
// Shared types, constants and helpers for the flag-delimited deframer.
package fdsd_pkg;

  localparam int FLAG_LEN_DEF = 4;
  localparam int SYM_W        = 4;
  localparam int PAT_W        = 16;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END   = 2'd2;

  typedef struct packed {
    logic sync_r;
    logic start_r;
    logic start_0;
    logic end_r;
    logic end_0;
  } match_t;

  function automatic logic [SYM_W-1:0] pat_nib(input logic [PAT_W-1:0] pat,
                                                input logic [3:0] k);
    logic [PAT_W-1:0] sh;
    sh = pat >> {k, 2'b00};
    return sh[SYM_W-1:0];
  endfunction

endpackage

// ===== design/flag_delimited_symbol_deframer.sv =====
// Flag-delimited symbol deframer: row of ring cells, phase control, output register.
// Takes one 4-bit tone symbol per cycle and registers a result for the cycle after the
// symbol is taken. The ring of the last FLAG_LEN symbols is a row of cells that
// each compare their entry with the sync, start and end flags; hunting sync,
// hunting start and collecting follow one another, several in one cycle if the
// ring already matches. Payload symbols come out FLAG_LEN symbols late, so the
// end flag never appears; the symbol due when the end flag matches rides in the
// frame_end result. in_stall rises only while the output register is full and
// stalled; otherwise every cycle can take a symbol. The user must write patterns
// on the cfg port only while no symbols are in flight; the block does not enforce it.
`include "assert_macros.svh"

module flag_delimited_symbol_deframer #(
  parameter int FLAG_LEN = fdsd_pkg::FLAG_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fdsd_pkg::SYM_W-1:0]    in_symbol,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fdsd_pkg::SYM_W-1:0]    out_data_symbol,
  output logic                          out_frame_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fdsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdsd_pkg::PAT_W-1:0]    cfg_data
);
  import fdsd_pkg::*;

  localparam int PW = $clog2(FLAG_LEN);
  localparam int CW = $clog2(FLAG_LEN + 1);

  localparam logic [1:0] PH_SYNC    = 2'd0;
  localparam logic [1:0] PH_START   = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  localparam logic [SYM_W:0] NO_PREV = (SYM_W+1)'(1 << SYM_W);

  logic [PAT_W-1:0] sync_pat_r, start_pat_r, end_pat_r;

  logic [1:0]       phase_r, phase_nxt;
  logic [PW-1:0]    wp_r, wp_nxt, wp1, wp_inc;
  logic [SYM_W:0]   prev_r, prev_nxt;
  logic [CW-1:0]    cc_r, cc_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_data_r;
  logic             out_end_r;

  logic             acc;
  logic             wr;
  logic             due;
  logic             check_end0;
  logic             res_valid, res_end;
  logic [SYM_W-1:0] res_data;
  logic [SYM_W-1:0] due_sym;

  match_t           mlink [0:FLAG_LEN];
  logic [SYM_W-1:0] dlink [0:FLAG_LEN];
  match_t           m;

  assign in_stall  = out_valid_r && out_stall;
  assign acc       = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_data_symbol = out_data_r;
  assign out_frame_end   = out_end_r;

  assign mlink[0] = '1;
  assign dlink[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < FLAG_LEN; gi++) begin : g_cell
      fdsd_cell #(
        .N   (FLAG_LEN),
        .IDX (gi),
        .PW  (PW)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .wr        (wr),
        .sym       (in_symbol),
        .wp        (wp_r),
        .wp1       (wp1),
        .sync_pat  (sync_pat_r),
        .start_pat (start_pat_r),
        .end_pat   (end_pat_r),
        .match_in  (mlink[gi]),
        .match_out (mlink[gi+1]),
        .due_in    (dlink[gi]),
        .due_out   (dlink[gi+1])
      );
    end
  endgenerate

  assign m       = mlink[FLAG_LEN];
  assign due_sym = dlink[FLAG_LEN];
  assign wp_inc  = (wp_r == PW'(FLAG_LEN - 1)) ? '0 : wp_r + PW'(1);
  assign wp1     = wr ? wp_inc : wp_r;

  always_comb begin
    wr = 1'b1;
    if (phase_r != PH_START && phase_r != PH_COLLECT) begin
      wr = ({1'b0, in_symbol} != prev_r);
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    wp_nxt     = wp1;
    prev_nxt   = prev_r;
    cc_nxt     = cc_r;
    res_valid  = 1'b0;
    res_end    = 1'b0;
    res_data   = '0;
    due        = 1'b0;
    check_end0 = 1'b0;
    case (phase_r)
      PH_COLLECT: begin
        due = (cc_r == CW'(FLAG_LEN));
        if (!due) begin
          cc_nxt = cc_r + CW'(1);
        end
        if (m.end_r) begin
          res_valid = 1'b1;
          res_end   = 1'b1;
          res_data  = due ? due_sym : '0;
          phase_nxt = PH_SYNC;
          wp_nxt    = '0;
          prev_nxt  = NO_PREV;
          cc_nxt    = '0;
        end else if (due) begin
          res_valid = 1'b1;
          res_data  = due_sym;
        end
      end
      PH_START: begin
        if (m.start_r) begin
          phase_nxt  = PH_COLLECT;
          wp_nxt     = '0;
          cc_nxt     = '0;
          check_end0 = 1'b1;
        end
      end
      default: begin
        if (wr) begin
          prev_nxt = {1'b0, in_symbol};
        end
        if (m.sync_r) begin
          wp_nxt = '0;
          if (m.start_0) begin
            phase_nxt  = PH_COLLECT;
            cc_nxt     = '0;
            check_end0 = 1'b1;
          end else begin
            phase_nxt = PH_START;
          end
        end
      end
    endcase
    if (check_end0 && m.end_0) begin
      res_valid = 1'b1;
      res_end   = 1'b1;
      res_data  = '0;
      phase_nxt = PH_SYNC;
      wp_nxt    = '0;
      prev_nxt  = NO_PREV;
      cc_nxt    = '0;
    end
  end

  always_comb begin
    if (acc && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC;
      wp_r        <= '0;
      prev_r      <= NO_PREV;
      cc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        phase_r <= phase_nxt;
        wp_r    <= wp_nxt;
        prev_r  <= prev_nxt;
        cc_r    <= cc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && res_valid) begin
      out_data_r <= res_data;
      out_end_r  <= res_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_pat_r  <= '0;
      start_pat_r <= '0;
      end_pat_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYNC:  sync_pat_r  <= cfg_data;
        REG_START: start_pat_r <= cfg_data;
        REG_END:   end_pat_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  `ASSERT_SAME(a_cc_bound, clk, rst_n, 1'b1, cc_r <= CW'(FLAG_LEN), "collect count overflow")
  `ASSERT_SAME(a_cc_idle, clk, rst_n, phase_r != PH_COLLECT, cc_r == '0, "count outside collect")
  `ASSERT_NEXT(a_end_sync, clk, rst_n, acc && res_valid && res_end, phase_r == PH_SYNC && wp_r == '0 && prev_r == NO_PREV && out_frame_end, "frame end not back to sync")

endmodule

// ===== design/fdsd_cell.sv =====
// One ring entry with its pattern compares and due-symbol select.
module fdsd_cell #(
  parameter int N   = fdsd_pkg::FLAG_LEN_DEF,
  parameter int IDX = 0,
  parameter int PW  = $clog2(N)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic                        wr,
  input  logic [fdsd_pkg::SYM_W-1:0]  sym,
  input  logic [PW-1:0]               wp,
  input  logic [PW-1:0]               wp1,
  input  logic [fdsd_pkg::PAT_W-1:0]  sync_pat,
  input  logic [fdsd_pkg::PAT_W-1:0]  start_pat,
  input  logic [fdsd_pkg::PAT_W-1:0]  end_pat,
  input  fdsd_pkg::match_t            match_in,
  output fdsd_pkg::match_t            match_out,
  input  logic [fdsd_pkg::SYM_W-1:0]  due_in,
  output logic [fdsd_pkg::SYM_W-1:0]  due_out
);
  import fdsd_pkg::*;

  logic [SYM_W-1:0] ent_r;
  logic [SYM_W-1:0] ent_nxt;
  logic             here;
  logic [PW:0]      diff;
  logic [3:0]       k_r;
  logic [3:0]       k_0;

  assign here    = (wp == PW'(IDX));
  assign ent_nxt = (wr && here) ? sym : ent_r;
  assign due_out = here ? ent_r : due_in;

  always_comb begin
    if ((PW+1)'(IDX) >= {1'b0, wp1}) begin
      diff = (PW+1)'(IDX) - {1'b0, wp1};
    end else begin
      diff = (PW+1)'(IDX + N) - {1'b0, wp1};
    end
  end

  assign k_r = 4'(diff);
  assign k_0 = 4'(IDX);

  assign match_out.sync_r  = match_in.sync_r  && (ent_nxt == pat_nib(sync_pat, k_r));
  assign match_out.start_r = match_in.start_r && (ent_nxt == pat_nib(start_pat, k_r));
  assign match_out.start_0 = match_in.start_0 && (ent_nxt == pat_nib(start_pat, k_0));
  assign match_out.end_r   = match_in.end_r   && (ent_nxt == pat_nib(end_pat, k_r));
  assign match_out.end_0   = match_in.end_0   && (ent_nxt == pat_nib(end_pat, k_0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else if (acc) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

// ===== sim/tb_flag_delimited_symbol_deframer.sv =====
// Self-checking testbench for the flag-delimited symbol deframer: framed and noisy symbol streams.
module tb_flag_delimited_symbol_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import fdsd_pkg::*;

  localparam int DEPTH = FLAG_LEN_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [4:0] NO_LAST_SYM = 5'd16;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef enum logic [1:0] {HUNT_SYNC, HUNT_START, COLLECT} deframe_phase_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [SYM_W-1:0] data_symbol;
    logic             frame_end;
  } frame_result_t;

  class frame_scoreboard;
    logic [PAT_W-1:0] sync_pat;
    logic [PAT_W-1:0] start_pat;
    logic [PAT_W-1:0] end_pat;
    logic [SYM_W-1:0] ring [DEPTH];
    logic [1:0]       wptr;
    deframe_phase_t   phase;
    logic [4:0]       last_sym;
    int               held;
    frame_result_t    expected_q[$];
    int               errors;

    function new();
      sync_pat = '0;
      start_pat = '0;
      end_pat = '0;
      foreach (ring[i]) ring[i] = '0;
      errors = 0;
      to_hunt();
    endfunction

    function void to_hunt();
      phase = HUNT_SYNC;
      wptr = '0;
      last_sym = NO_LAST_SYM;
      held = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAT_W-1:0] val);
      case (idx)
        REG_SYNC:  sync_pat = val;
        REG_START: start_pat = val;
        REG_END:   end_pat = val;
        default: ;
      endcase
    endfunction

    function bit ring_is(logic [PAT_W-1:0] pat);
      logic [1:0] slot;
      for (int i = 0; i < DEPTH; i++) begin
        slot = wptr + 2'(i);
        if (ring[slot] != pat[SYM_W*i +: SYM_W]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void push_symbol(logic [SYM_W-1:0] s);
      ring[wptr] = s;
      wptr = wptr + 2'd1;
    endfunction

    function void note_symbol(logic [SYM_W-1:0] s);
      bit               due;
      logic [SYM_W-1:0] due_sym;
      frame_result_t    r;
      due = 1'b0;
      due_sym = '0;
      case (phase)
        COLLECT: begin
          if (held >= DEPTH) begin
            due = 1'b1;
            due_sym = ring[wptr];
          end
          push_symbol(s);
          if (held < DEPTH) held++;
        end
        HUNT_START: push_symbol(s);
        default: begin
          if ({1'b0, s} != last_sym) begin
            push_symbol(s);
            last_sym = {1'b0, s};
          end
          if (!ring_is(sync_pat)) return;
          phase = HUNT_START;
          wptr = '0;
        end
      endcase
      if (phase == HUNT_START) begin
        if (!ring_is(start_pat)) return;
        phase = COLLECT;
        wptr = '0;
        held = 0;
      end
      if (ring_is(end_pat)) begin
        r.data_symbol = due ? due_sym : '0;
        r.frame_end = 1'b1;
        expected_q = {expected_q, r};
        to_hunt();
      end else if (due) begin
        r.data_symbol = due_sym;
        r.frame_end = 1'b0;
        expected_q = {expected_q, r};
      end
    endfunction

    function void check_result(logic [SYM_W-1:0] data, logic fe);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, data_symbol=%h frame_end=%b", $time, data, fe);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data_symbol) begin
        $display("%0t: data_symbol mismatch, expected %h, got %h", $time,
                 want.data_symbol, data);
        errors++;
      end
      if (fe !== want.frame_end) begin
        $display("%0t: frame_end mismatch, expected %b, got %b", $time, want.frame_end, fe);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SYM_W-1:0]     in_symbol = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SYM_W-1:0]     out_data_symbol;
  logic                 out_frame_end;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PAT_W-1:0]     cfg_data = '0;

  frame_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;
  int sent = 0;
  int quiet = 0;

  flag_delimited_symbol_deframer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_symbol      (in_symbol),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_symbol(out_data_symbol),
    .out_frame_end  (out_frame_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_data_symbol, out_frame_end);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("[flag_delimited_symbol_deframer] ERROR");
        $finish;
      end
    end
  end

  task automatic send_symbol(input logic [SYM_W-1:0] s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_symbol <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_symbol(s);
    sent++;
  endtask

  // sync, start flag, payload, end flag; a broken frame has one symbol hit or is cut short
  task automatic send_frame(input int pay_len, input bit broken, input bit extreme_payload);
    logic [SYM_W-1:0] seq[$];
    logic [SYM_W-1:0] nib;
    int               n_send;
    for (int i = 0; i < DEPTH; i++) begin
      nib = sb.sync_pat[SYM_W*i +: SYM_W];
      seq = {seq, nib};
    end
    for (int i = 0; i < DEPTH; i++) begin
      nib = sb.start_pat[SYM_W*i +: SYM_W];
      seq = {seq, nib};
    end
    for (int i = 0; i < pay_len; i++) begin
      nib = extreme_payload ? ((i % 2) ? 4'hF : 4'h0) : 4'($urandom);
      seq = {seq, nib};
    end
    for (int i = 0; i < DEPTH; i++) begin
      nib = sb.end_pat[SYM_W*i +: SYM_W];
      seq = {seq, nib};
    end
    n_send = seq.size();
    if (broken) begin
      if ($urandom_range(1)) seq[$urandom_range(seq.size() - 1)] = 4'($urandom);
      else n_send = $urandom_range(1, seq.size() - 1);
    end
    for (int i = 0; i < n_send; i++) send_symbol(seq[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_patterns(input logic [PAT_W-1:0] sync_v, input logic [PAT_W-1:0] start_v,
                                  input logic [PAT_W-1:0] end_v, input bit touch_unused);
    logic [CFG_IDX_W-1:0] idx[$];
    logic [PAT_W-1:0]     val[$];
    logic [PAT_W-1:0]     junk;
    idx = {idx, REG_SYNC};
    val = {val, sync_v};
    if (touch_unused) begin
      junk = PAT_W'($urandom);
      idx = {idx, REG_UNUSED};
      val = {val, junk};
    end
    idx = {idx, REG_START};
    val = {val, start_v};
    idx = {idx, REG_END};
    val = {val, end_v};
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // neighbors differ, since repeats are dropped while hunting sync
  function automatic logic [PAT_W-1:0] rand_sync();
    logic [SYM_W-1:0] prev;
    logic [SYM_W-1:0] nib;
    logic [PAT_W-1:0] v;
    prev = 4'($urandom);
    v = '0;
    v[SYM_W-1:0] = prev;
    for (int i = 1; i < DEPTH; i++) begin
      nib = 4'($urandom);
      while (nib == prev) nib = 4'($urandom);
      v[SYM_W*i +: SYM_W] = nib;
      prev = nib;
    end
    return v;
  endfunction

  task automatic run_phase(input int n_items, input idle_mode_t mode);
    int first;
    int r;
    int len;
    tx_idle_pct = (mode == IDLE_SENDER) ? 65 : (mode == IDLE_BOTH) ? 17 : 0;
    rx_stall_pct = (mode == IDLE_RECEIVER) ? 65 : (mode == IDLE_BOTH) ? 17 : 0;
    first = sent;
    while (sent - first < n_items) begin
      r = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(6);
      if (r < 70) send_frame(len, 1'b0, 1'b0);
      else if (r < 85) send_frame(len, 1'b1, 1'b0);
      else repeat ($urandom_range(1, 4)) send_symbol(4'($urandom));
    end
  endtask

  initial begin
    logic [PAT_W-1:0] shared;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // all-zero patterns: one symbol passes every phase and closes an empty frame
    send_symbol(4'h0);
    send_symbol(4'hF);
    send_symbol(4'hF);
    drain();
    program_patterns(16'h4321, 16'h8765, 16'hCBA9, 1'b0);
    send_frame(0, 1'b0, 1'b0);
    send_frame(2, 1'b0, 1'b1);
    send_frame(1, 1'b0, 1'b1);

    for (int k = 0; k < 9; k++) begin
      drain();
      shared = PAT_W'($urandom);
      case (k)
        4: program_patterns(rand_sync(), 16'hFFFF, 16'h0000, 1'b0);
        5: program_patterns(rand_sync(), shared, shared, 1'b1);
        6: program_patterns(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        8: begin
          shared = rand_sync();
          program_patterns(shared, shared, PAT_W'($urandom), 1'b0);
        end
        default: program_patterns(rand_sync(), PAT_W'($urandom), PAT_W'($urandom), k == 0);
      endcase
      if (k == 0) hold_left = HOLD_OFF_CYCLES;
      if (k == 3) begin
        run_phase(40, IDLE_BOTH);
        drain();
        run_phase(35, IDLE_BOTH);
      end else begin
        run_phase((k == 6) ? 40 : 75, idle_mode_t'(k % 4));
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[flag_delimited_symbol_deframer] OK");
    end else begin
      $display("[flag_delimited_symbol_deframer] ERROR");
    end
    $finish;
  end

endmodule
